@@ hdl/u16u8_pkg.sv @@
// Shared types and constants for the UTF-16 to UTF-8 encoder.
// Used by the front, queue, back and top-level modules; no dependencies.
`default_nettype none
package u16u8_pkg;

  localparam int UNIT_W      = 16;
  localparam int SCALAR_W    = 21;
  localparam int SURR_W      = 10;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int OUT_DATA_W  = 40;

  localparam logic [UNIT_W-1:0]   BOM_SWAPPED   = 16'hFFFE;
  localparam logic [UNIT_W-1:0]   BOM_NATIVE    = 16'hFEFF;
  localparam logic [UNIT_W-1:0]   SURR_LO       = 16'hD800;
  localparam logic [UNIT_W-1:0]   SURR_HI       = 16'hDFFF;
  localparam logic [UNIT_W-1:0]   ONE_BYTE_MAX  = 16'h007F;
  localparam logic [UNIT_W-1:0]   TWO_BYTE_MAX  = 16'h07FF;
  localparam logic [SCALAR_W-1:0] SUPP_OFFSET   = 21'h10000;

  localparam logic [4:0] LEAD4_TAG = 5'b11110;
  localparam logic [3:0] LEAD3_TAG = 4'b1110;
  localparam logic [2:0] LEAD2_TAG = 3'b110;
  localparam logic [1:0] CONT_TAG  = 2'b10;

  // Encoding kind; its value is the number of bytes produced.
  typedef enum logic [2:0] {
    KIND_NONE  = 3'd0,
    KIND_ONE   = 3'd1,
    KIND_TWO   = 3'd2,
    KIND_THREE = 3'd3,
    KIND_FOUR  = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [SCALAR_W-1:0] value;
  } cmd_t;

endpackage
`default_nettype wire

@@ hdl/u16u8_front.sv @@
// Front end: accepts code units, tracks byte order and held surrogate,
// classifies each unit into an encoding command. Depends on u16u8_pkg.
`default_nettype none
module u16u8_front import u16u8_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [UNIT_W-1:0] in_tdata,   // [15:0] code_unit
  input  wire logic              in_tuser,   // [0] first_unit
  output logic                   push_valid,
  output cmd_t                   push_cmd,
  input  wire logic              push_ready
);

  logic              swap_r, swap_nxt;
  logic [SURR_W-1:0] pend_high_r, pend_high_nxt;
  logic              pend_valid_r, pend_valid_nxt;

  logic              accept;
  logic              swap_eff;
  logic              pend_eff;
  logic              is_mark;
  logic [UNIT_W-1:0] unit;

  assign in_tready  = push_ready;
  assign accept     = in_tvalid && in_tready;
  assign push_valid = in_tvalid;

  always_comb begin
    swap_eff = in_tuser ? (in_tdata == BOM_SWAPPED) : swap_r;
    pend_eff = in_tuser ? 1'b0 : pend_valid_r;
    is_mark  = in_tuser && ((in_tdata == BOM_SWAPPED) || (in_tdata == BOM_NATIVE));
    unit     = swap_eff ? {in_tdata[7:0], in_tdata[15:8]} : in_tdata;
  end

  always_comb begin
    push_cmd.kind  = KIND_NONE;
    push_cmd.value = {{(SCALAR_W-UNIT_W){1'b0}}, unit};
    pend_high_nxt  = in_tuser ? '0 : pend_high_r;
    pend_valid_nxt = pend_eff;
    if (is_mark) begin
      push_cmd.kind = KIND_NONE;
    end else if (pend_eff) begin
      push_cmd.kind  = KIND_FOUR;
      push_cmd.value = {1'b0, pend_high_r, unit[SURR_W-1:0]} + SUPP_OFFSET;
      pend_high_nxt  = '0;
      pend_valid_nxt = 1'b0;
    end else if (unit <= ONE_BYTE_MAX) begin
      push_cmd.kind = KIND_ONE;
    end else if (unit <= TWO_BYTE_MAX) begin
      push_cmd.kind = KIND_TWO;
    end else if (unit >= SURR_LO && unit <= SURR_HI) begin
      // either half of a pair is held and combined with the next unit
      push_cmd.kind  = KIND_NONE;
      pend_high_nxt  = unit[SURR_W-1:0];
      pend_valid_nxt = 1'b1;
    end else begin
      push_cmd.kind = KIND_THREE;
    end
    swap_nxt = swap_eff;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      swap_r       <= 1'b0;
      pend_high_r  <= '0;
      pend_valid_r <= 1'b0;
    end else if (accept) begin
      swap_r       <= swap_nxt;
      pend_high_r  <= pend_high_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

endmodule
`default_nettype wire

@@ hdl/u16u8_queue.sv @@
// Short command queue between the front and back ends.
// Flip-flop storage, depth from u16u8_pkg::QUEUE_DEPTH.
`default_nettype none
module u16u8_queue import u16u8_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push_valid,
  input  wire cmd_t push_cmd,
  output logic      push_ready,
  output logic      pop_valid,
  output cmd_t      pop_cmd,
  input  wire logic pop_ready
);

  cmd_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              push, pop;

  assign push_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = slot_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue occupancy above depth");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count missed a push");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("empty queue with misaligned pointers");

endmodule
`default_nettype wire

@@ hdl/u16u8_back.sv @@
// Back end: turns encoding commands into packed UTF-8 bytes and a count,
// holding them in the output register. Depends on u16u8_pkg.
`default_nettype none
module u16u8_back import u16u8_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  pop_valid,
  input  wire cmd_t                  pop_cmd,
  output logic                       pop_ready,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata  // [7:0] byte0, [15:8] byte1,
                                                // [23:16] byte2, [31:24] byte3,
                                                // [34:32] byte_count
);

  logic                  valid_r;
  logic [OUT_DATA_W-1:0] data_r, data_nxt;
  logic [7:0]            b0, b1, b2, b3;
  logic [SCALAR_W-1:0]   v;

  assign v          = pop_cmd.value;
  assign pop_ready  = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;

  always_comb begin
    b0 = '0;
    b1 = '0;
    b2 = '0;
    b3 = '0;
    unique case (pop_cmd.kind)
      KIND_ONE: begin
        b0 = {1'b0, v[6:0]};
      end
      KIND_TWO: begin
        b0 = {LEAD2_TAG, v[10:6]};
        b1 = {CONT_TAG, v[5:0]};
      end
      KIND_THREE: begin
        b0 = {LEAD3_TAG, v[15:12]};
        b1 = {CONT_TAG, v[11:6]};
        b2 = {CONT_TAG, v[5:0]};
      end
      KIND_FOUR: begin
        b0 = {LEAD4_TAG, v[20:18]};
        b1 = {CONT_TAG, v[17:12]};
        b2 = {CONT_TAG, v[11:6]};
        b3 = {CONT_TAG, v[5:0]};
      end
      default: begin
      end
    endcase
    data_nxt = {{(OUT_DATA_W-35){1'b0}}, 3'(pop_cmd.kind), b3, b2, b1, b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop_ready) begin
      valid_r <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_ready && pop_valid) begin
      data_r <= data_nxt;
    end
  end

  a_four_lead: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && data_r[34:32] == 3'd4) |-> (data_r[7:3] == LEAD4_TAG))
    else $error("four-byte item without a four-byte lead");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && data_r[34:32] == 3'd0) |-> (data_r[31:0] == '0))
    else $error("empty item carries nonzero bytes");

endmodule
`default_nettype wire

@@ hdl/utf16_to_utf8_encoder.sv @@
// UTF-16 to UTF-8 encoder: one 16-bit code unit in, one packed result out.
// Accepted units go through a 2-entry command queue that decouples front and back, then
// the output register. Throughput: one code unit per cycle unless the queue is full.
// Reset (synchronous, rst_n low): native byte order, no surrogate held, queue and
// output register empty.
`default_nettype none
module utf16_to_utf8_encoder import u16u8_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [UNIT_W-1:0]     in_tdata,   // [15:0] code_unit
  input  wire logic                  in_tuser,   // [0] first_unit
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata   // [7:0] byte0, [15:8] byte1,
                                                 // [23:16] byte2, [31:24] byte3,
                                                 // [34:32] byte_count
);

  logic push_valid, push_ready;
  cmd_t push_cmd;
  logic pop_valid, pop_ready;
  cmd_t pop_cmd;

  u16u8_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready)
  );

  u16u8_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_cmd    (pop_cmd),
    .pop_ready  (pop_ready)
  );

  u16u8_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_cmd    (pop_cmd),
    .pop_ready  (pop_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire
